### rtl/core/vad_pkg.sv
`timescale 1ns / 1ps

package vad_pkg;

    localparam int DEF_INPUT_WIDTH   = 24;
    localparam int DEF_FRACTION_BITS = 16;

    // table is stored with 16 fraction bits and rescaled in the datapath
    localparam int TAB_FRAC  = 16;
    localparam int TAB_WIDTH = 22;
    localparam int TAB_DEPTH = 65;
    localparam int IDX_WIDTH = $clog2(TAB_DEPTH);

    // octant code: {|x| < |y|, y negative, x negative}
    typedef enum logic [2:0] {
        OCT_XP_YP_FLAT  = 3'd0,
        OCT_XN_YP_FLAT  = 3'd1,
        OCT_XP_YN_FLAT  = 3'd2,
        OCT_XN_YN_FLAT  = 3'd3,
        OCT_XP_YP_STEEP = 3'd4,
        OCT_XN_YP_STEEP = 3'd5,
        OCT_XP_YN_STEEP = 3'd6,
        OCT_XN_YN_STEEP = 3'd7
    } t_octant;

    // atan(i/64) in degrees, 16 fraction bits, rounded to nearest
    localparam logic [TAB_WIDTH-1:0] ATAN_TAB [0:TAB_DEPTH-1] = '{
        22'd0,       22'd58666,   22'd117304,  22'd175884,
        22'd234379,  22'd292760,  22'd350999,  22'd409070,
        22'd466945,  22'd524598,  22'd582003,  22'd639135,
        22'd695970,  22'd752484,  22'd808654,  22'd864460,
        22'd919879,  22'd974893,  22'd1029481, 22'd1083627,
        22'd1137313, 22'd1190524, 22'd1243245, 22'd1295461,
        22'd1347161, 22'd1398332, 22'd1448965, 22'd1499049,
        22'd1548575, 22'd1597536, 22'd1645926, 22'd1693738,
        22'd1740967, 22'd1787610, 22'd1833663, 22'd1879123,
        22'd1923990, 22'd1968261, 22'd2011937, 22'd2055018,
        22'd2097505, 22'd2139399, 22'd2180703, 22'd2221419,
        22'd2261551, 22'd2301101, 22'd2340074, 22'd2378474,
        22'd2416306, 22'd2453574, 22'd2490285, 22'd2526443,
        22'd2562055, 22'd2597127, 22'd2631664, 22'd2665673,
        22'd2699161, 22'd2732134, 22'd2764600, 22'd2796564,
        22'd2828035, 22'd2859019, 22'd2889523, 22'd2919554,
        22'd2949120
    };

endpackage

### rtl/core/vector_angle_degrees.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; the ratio divider
// is unrolled to one quotient bit per register stage, followed by table lookup,
// multiply and octant-map stages.
// The whole pipeline advances together when the output register is free or taken.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
module vector_angle_degrees #(
    parameter int INPUT_WIDTH   = vad_pkg::DEF_INPUT_WIDTH,
    parameter int FRACTION_BITS = vad_pkg::DEF_FRACTION_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [INPUT_WIDTH-1:0]     i_vec_x,
    input  logic [INPUT_WIDTH-1:0]     i_vec_y,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [FRACTION_BITS+8:0]   o_angle_deg
);

    localparam int W   = INPUT_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int QW  = F + 7;              // quotient holds 0 .. 64 << F
    localparam int TW  = F + 6;              // scaled table entry width
    localparam int OW  = F + 9;
    localparam int IW  = vad_pkg::IDX_WIDTH;
    localparam int SH_L = (F >= vad_pkg::TAB_FRAC) ? F - vad_pkg::TAB_FRAC : 0;
    localparam int SH_R = (F < vad_pkg::TAB_FRAC) ? vad_pkg::TAB_FRAC - F : 0;
    localparam int RND_SH = (SH_R > 0) ? SH_R - 1 : 0;
    localparam int XW  = vad_pkg::TAB_WIDTH + 1 + SH_L;
    localparam logic [vad_pkg::TAB_WIDTH:0] RND =
        (SH_R > 0) ? ((vad_pkg::TAB_WIDTH+1)'(1) << RND_SH) : '0;
    localparam logic [IW-1:0] IDX_LAST = IW'(vad_pkg::TAB_DEPTH - 1);

    localparam logic [OW-1:0] DEG45  = OW'(45)  << F;
    localparam logic [OW-1:0] DEG90  = OW'(90)  << F;
    localparam logic [OW-1:0] DEG180 = OW'(180) << F;
    localparam logic [OW-1:0] DEG270 = OW'(270) << F;
    localparam logic [OW-1:0] DEG360 = OW'(360) << F;

    function automatic logic [TW-1:0] tab_scale(input logic [vad_pkg::TAB_WIDTH-1:0] v);
        logic [vad_pkg::TAB_WIDTH:0] rnd;
        logic [XW-1:0]               tmp;
        rnd = ({1'b0, v} + RND) >> SH_R;
        tmp = XW'(rnd) << SH_L;
        return TW'(tmp);
    endfunction

    // whole pipeline moves when the output register is empty or being taken
    logic w_adv;
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // ---------------- front: magnitudes and octant ----------------
    logic         w_nx, w_ny, w_steep;
    logic [W-1:0] w_ax, w_ay;

    assign w_nx    = i_vec_x[W-1];
    assign w_ny    = i_vec_y[W-1];
    assign w_ax    = w_nx ? (~i_vec_x + W'(1)) : i_vec_x;
    assign w_ay    = w_ny ? (~i_vec_y + W'(1)) : i_vec_y;
    assign w_steep = w_ax < w_ay;

    logic              r_vld   [0:QW];
    logic [W-1:0]      r_rem   [0:QW];
    logic [W-1:0]      r_large [0:QW];
    logic [QW-1:0]     r_q     [0:QW];
    vad_pkg::t_octant  r_oct   [0:QW];
    logic              r_zero  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem[0]   <= w_steep ? w_ax : w_ay;
            r_large[0] <= w_steep ? w_ay : w_ax;
            r_q[0]     <= '0;
            r_oct[0]   <= vad_pkg::t_octant'({w_steep, w_ny, w_nx});
            r_zero[0]  <= (w_ax == '0) && (w_ay == '0);
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    // remainder stays below the divisor, so doubling it still fits in W bits
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [W-1:0] w_trial;
        logic         w_bit;

        assign w_trial = (j == 0) ? r_rem[j] : (r_rem[j] << 1);
        assign w_bit   = w_trial >= r_large[j];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rem[j+1]   <= w_bit ? (w_trial - r_large[j]) : w_trial;
                r_large[j+1] <= r_large[j];
                r_q[j+1]     <= {r_q[j][QW-2:0], w_bit};
                r_oct[j+1]   <= r_oct[j];
                r_zero[j+1]  <= r_zero[j];
            end
        end
    end

    // ---------------- table lookup ----------------
    logic [IW-1:0] w_idx, w_nxt;
    logic [TW-1:0] w_lo, w_hi;

    assign w_idx = r_q[QW][QW-1:F];
    assign w_nxt = (w_idx == IDX_LAST) ? IDX_LAST : (w_idx + IW'(1));
    assign w_lo  = tab_scale(vad_pkg::ATAN_TAB[w_idx]);
    assign w_hi  = tab_scale(vad_pkg::ATAN_TAB[w_nxt]);

    logic             r_vld_a;
    logic [TW-1:0]    r_lo_a, r_diff_a;
    logic [F-1:0]     r_frac_a;
    vad_pkg::t_octant r_oct_a;
    logic             r_zero_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (w_adv) begin
            r_vld_a <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lo_a   <= w_lo;
            r_diff_a <= w_hi - w_lo;
            r_frac_a <= r_q[QW][F-1:0];
            r_oct_a  <= r_oct[QW];
            r_zero_a <= r_zero[QW];
        end
    end

    // ---------------- interpolation multiply ----------------
    logic             r_vld_b;
    logic [TW-1:0]    r_lo_b;
    logic [TW+F-1:0]  r_prod_b;
    vad_pkg::t_octant r_oct_b;
    logic             r_zero_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (w_adv) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lo_b   <= r_lo_a;
            r_prod_b <= (TW+F)'(r_diff_a) * (TW+F)'(r_frac_a);
            r_oct_b  <= r_oct_a;
            r_zero_b <= r_zero_a;
        end
    end

    // ---------------- octant map ----------------
    logic [OW-1:0] w_a, w_ang;

    assign w_a = OW'(r_lo_b + r_prod_b[TW+F-1:F]);

    always_comb begin
        case (r_oct_b)
            vad_pkg::OCT_XP_YP_FLAT:  w_ang = w_a;
            vad_pkg::OCT_XN_YP_FLAT:  w_ang = DEG180 - w_a;
            vad_pkg::OCT_XP_YN_FLAT:  w_ang = DEG360 - w_a;
            vad_pkg::OCT_XN_YN_FLAT:  w_ang = DEG180 + w_a;
            vad_pkg::OCT_XP_YP_STEEP: w_ang = DEG90 - w_a;
            vad_pkg::OCT_XN_YP_STEEP: w_ang = DEG90 + w_a;
            vad_pkg::OCT_XP_YN_STEEP: w_ang = DEG270 + w_a;
            vad_pkg::OCT_XN_YN_STEEP: w_ang = DEG270 - w_a;
            default:                  w_ang = w_a;
        endcase
    end

    logic          r_out_vld;
    logic [OW-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_angle <= r_zero_b ? '0 : w_ang;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_angle_deg = r_angle;

    // ---------------- checks ----------------
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW] && !r_zero[QW] |-> r_rem[QW] < r_large[QW])
        else $error("divider remainder not below divisor");

    a_div_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QW] && !r_zero[QW] |-> w_idx <= IDX_LAST)
        else $error("ratio above 64");

    a_interp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_b && !r_zero_b |-> w_a <= DEG45)
        else $error("interpolated angle above 45 degrees");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_angle_deg <= DEG360)
        else $error("angle above 360 degrees");

endmodule
